// ----- rtl/pwm_period_duty_meter_macros.svh -----
// Assertion macros shared by the checker of the PWM period and duty meter.
`ifndef PWM_PERIOD_DUTY_METER_MACROS_SVH
`define PWM_PERIOD_DUTY_METER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define PDM_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pwm_period_duty_meter check failed");

// Checks a property at every rising clock edge, reset included.
`define PDM_CHECK_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pwm_period_duty_meter reset check failed");

`endif

// ----- rtl/pdm_pkg.sv -----
// Shared constants and types of the PWM period and duty meter.
package pdm_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int RATE_WIDTH = 27;
	localparam int HIGH_W = 32;
	localparam int PERIOD_W = 33;
	localparam int DUTY_W = 7;
	localparam int FREQ_W = 26;
	localparam int DUTY_SCALE = 100;
	localparam logic [RATE_WIDTH-1:0] TICK_RATE_RESET = 27'd8000000;

	typedef struct packed {
		logic full;
		logic empty;
	} pdm_qstat_t;

endpackage

// ----- rtl/pdm_front.sv -----
// Front end: edge detection and phase counting, pushes each finished period.
module pdm_front #(
	parameter int COUNT_WIDTH = pdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       signal_level,
	input  pdm_pkg::pdm_qstat_t        qstat,
	output logic                       push,
	output logic [2*COUNT_WIDTH-1:0]   push_data
);
	import pdm_pkg::*;

	logic                   accept;
	logic                   rise;
	logic                   fall;
	logic                   prev_level_q;
	logic                   armed_q;
	logic                   in_high_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] held_q;
	logic [COUNT_WIDTH-1:0] count_inc;

	assign in_stall  = qstat.full;
	assign accept    = in_valid && !qstat.full;
	assign rise      = signal_level && !prev_level_q;
	assign fall      = !signal_level && prev_level_q;
	assign count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + COUNT_WIDTH'(1);
	assign push      = accept && armed_q && !in_high_q && rise;
	assign push_data = {held_q, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			armed_q      <= 1'b0;
			in_high_q    <= 1'b0;
			count_q      <= '0;
			held_q       <= '0;
		end else if (accept) begin
			prev_level_q <= signal_level;
			if (!armed_q) begin
				if (rise) begin
					armed_q   <= 1'b1;
					in_high_q <= 1'b1;
					count_q   <= COUNT_WIDTH'(1);
				end
			end else if (in_high_q) begin
				if (fall) begin
					held_q    <= count_q;
					in_high_q <= 1'b0;
					count_q   <= COUNT_WIDTH'(1);
				end else begin
					count_q <= count_inc;
				end
			end else begin
				if (rise) begin
					in_high_q <= 1'b1;
					count_q   <= COUNT_WIDTH'(1);
				end else begin
					count_q <= count_inc;
				end
			end
		end
	end

endmodule

// ----- rtl/pdm_fifo.sv -----
// Short queue of finished periods between the front and the back end.
module pdm_fifo #(
	parameter int WIDTH = 2 * pdm_pkg::COUNT_WIDTH_DEF,
	parameter int DEPTH = pdm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    head_data,
	output pdm_pkg::pdm_qstat_t qstat
);
	import pdm_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	assign head_data   = mem_q[rd_ptr_q];
	assign qstat.full  = (fill_q == CW'(DEPTH));
	assign qstat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/pdm_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
module pdm_div #(
	parameter int DW = 34,
	parameter int VW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	import pdm_pkg::*;

	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [NW-1:0] left_q;
	logic [VW:0]   rem_sh;
	logic [VW+1:0] diff;
	logic          ge;

	assign rem_sh   = {rem_q, quo_q[DW-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign ge       = !diff[VW+1];
	assign busy     = (left_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (start) begin
			left_q <= NW'(DW);
		end else if (busy) begin
			left_q <= left_q - NW'(1);
		end
	end

endmodule

// ----- rtl/pdm_back.sv -----
// Back end: period sum, duty and frequency divisions and the result register.
module pdm_back #(
	parameter int COUNT_WIDTH = pdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pdm_pkg::RATE_WIDTH-1:0]    tick_rate,
	input  pdm_pkg::pdm_qstat_t               qstat,
	output logic                              pop,
	input  logic [2*COUNT_WIDTH-1:0]          head_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pdm_pkg::HIGH_W-1:0]        high_ticks,
	output logic [pdm_pkg::HIGH_W-1:0]        low_ticks,
	output logic [pdm_pkg::PERIOD_W-1:0]      period_ticks,
	output logic [pdm_pkg::DUTY_W-1:0]        duty_percent,
	output logic [pdm_pkg::FREQ_W-1:0]        frequency_hz
);
	import pdm_pkg::*;

	localparam int PDW = COUNT_WIDTH + 1;
	localparam int DDW = COUNT_WIDTH + DUTY_W;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                    state_q;
	logic                      out_valid_q;
	logic [COUNT_WIDTH-1:0]    hi_q;
	logic [COUNT_WIDTH-1:0]    lo_q;
	logic [PDW-1:0]            period_q;
	logic [COUNT_WIDTH-1:0]    head_hi;
	logic [COUNT_WIDTH-1:0]    head_lo;
	logic [PDW-1:0]            head_period;
	logic [DDW-1:0]            duty_dividend;
	logic                      duty_busy;
	logic                      freq_busy;
	logic [DDW-1:0]            duty_quo;
	logic [RATE_WIDTH-1:0]     freq_quo;
	logic                      finish;
	logic [COUNT_WIDTH+HIGH_W-1:0]  hi_ext;
	logic [COUNT_WIDTH+HIGH_W-1:0]  lo_ext;
	logic [PDW+PERIOD_W-1:0]        period_ext;

	assign head_hi       = head_data[2*COUNT_WIDTH-1:COUNT_WIDTH];
	assign head_lo       = head_data[COUNT_WIDTH-1:0];
	assign head_period   = {1'b0, head_hi} + {1'b0, head_lo};
	assign duty_dividend = {{DUTY_W{1'b0}}, head_hi} * DDW'(DUTY_SCALE);
	assign pop           = (state_q == ST_IDLE) && !qstat.empty;
	assign finish        = (state_q == ST_RUN) && !duty_busy && !freq_busy
		&& (!out_valid_q || !out_stall);
	assign hi_ext        = {{HIGH_W{1'b0}}, hi_q};
	assign lo_ext        = {{HIGH_W{1'b0}}, lo_q};
	assign period_ext    = {{PERIOD_W{1'b0}}, period_q};
	assign out_valid     = out_valid_q;

	pdm_div #(
		.DW(DDW),
		.VW(PDW)
	) u_duty_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pop),
		.dividend (duty_dividend),
		.divisor  (head_period),
		.busy     (duty_busy),
		.quotient (duty_quo)
	);

	pdm_div #(
		.DW(RATE_WIDTH),
		.VW(PDW)
	) u_freq_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pop),
		.dividend (tick_rate),
		.divisor  (head_period),
		.busy     (freq_busy),
		.quotient (freq_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			hi_q         <= '0;
			lo_q         <= '0;
			period_q     <= '0;
			high_ticks   <= '0;
			low_ticks    <= '0;
			period_ticks <= '0;
			duty_percent <= '0;
			frequency_hz <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
			if (pop) begin
				hi_q     <= head_hi;
				lo_q     <= head_lo;
				period_q <= head_period;
			end
			if (finish) begin
				out_valid_q  <= 1'b1;
				high_ticks   <= hi_ext[HIGH_W-1:0];
				low_ticks    <= lo_ext[HIGH_W-1:0];
				period_ticks <= period_ext[PERIOD_W-1:0];
				duty_percent <= duty_quo[DUTY_W-1:0];
				frequency_hz <= freq_quo[RATE_WIDTH-1] ? {FREQ_W{1'b1}}
					: freq_quo[FREQ_W-1:0];
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/pwm_period_duty_meter.sv -----
// Top level of the PWM period and duty meter: configuration register and the three parts.
// One sample is taken per cycle while the period queue has room.
// A closed period goes through the queue, the bit-serial dividers and the result register;
// the back end takes no new period before it has finished the last one.
// Asynchronous active-low reset clears the control state and sets the tick rate to 8000000.
module pwm_period_duty_meter #(
	parameter int COUNT_WIDTH = pdm_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = pdm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdm_pkg::RATE_WIDTH-1:0]  tick_rate_hz,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            signal_level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pdm_pkg::HIGH_W-1:0]      high_ticks,
	output logic [pdm_pkg::HIGH_W-1:0]      low_ticks,
	output logic [pdm_pkg::PERIOD_W-1:0]    period_ticks,
	output logic [pdm_pkg::DUTY_W-1:0]      duty_percent,
	output logic [pdm_pkg::FREQ_W-1:0]      frequency_hz
);
	import pdm_pkg::*;

	logic [RATE_WIDTH-1:0]    tick_rate_q;
	pdm_qstat_t               qstat;
	logic                     push;
	logic                     pop;
	logic [2*COUNT_WIDTH-1:0] push_data;
	logic [2*COUNT_WIDTH-1:0] head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RESET;
		end else if (cfg_valid) begin
			tick_rate_q <= tick_rate_hz;
		end
	end

	pdm_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.signal_level (signal_level),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	pdm_fifo #(
		.WIDTH(2 * COUNT_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.qstat     (qstat)
	);

	pdm_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_rate    (tick_rate_q),
		.qstat        (qstat),
		.pop          (pop),
		.head_data    (head_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.high_ticks   (high_ticks),
		.low_ticks    (low_ticks),
		.period_ticks (period_ticks),
		.duty_percent (duty_percent),
		.frequency_hz (frequency_hz)
	);

endmodule

// ----- rtl/pdm_checker.sv -----
// Port-level checker of the PWM period and duty meter and its binding.
`include "pwm_period_duty_meter_macros.svh"

module pdm_checker #(
	parameter int COUNT_WIDTH = pdm_pkg::COUNT_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pdm_pkg::HIGH_W-1:0]    high_ticks,
	input logic [pdm_pkg::HIGH_W-1:0]    low_ticks,
	input logic [pdm_pkg::PERIOD_W-1:0]  period_ticks,
	input logic [pdm_pkg::DUTY_W-1:0]    duty_percent
);
	import pdm_pkg::*;

	logic                sum_ok;
	logic [PERIOD_W-1:0] sum_ticks;

	assign sum_ticks = {1'b0, high_ticks} + {1'b0, low_ticks};
	assign sum_ok    = (COUNT_WIDTH > HIGH_W) || (sum_ticks == period_ticks);

	`PDM_CHECK(a_result_held, out_valid && out_stall |=> out_valid)
	`PDM_CHECK(a_period_sum, out_valid |-> sum_ok)
	`PDM_CHECK(a_duty_range, out_valid |-> duty_percent <= DUTY_W'(DUTY_SCALE))
	`PDM_CHECK_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid)

endmodule

bind pwm_period_duty_meter pdm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_pdm_checker (.*);

// ----- dv/pwm_period_duty_meter_test.sv -----
// Self-checking testbench of the PWM period and duty meter, with its own model of the meter.
module pwm_period_duty_meter_test;
	import pdm_pkg::*;

	localparam int LATENCY_CYCLES = COUNT_WIDTH_DEF + 9;
	localparam int SETTLE_CYCLES = LATENCY_CYCLES + 24;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_WAIT = 17;
	localparam int REPORT_LIMIT = 10;
	localparam logic [RATE_WIDTH-1:0] RATE_TOP = '1;

	typedef struct packed {
		logic [HIGH_W-1:0]   high_len;
		logic [HIGH_W-1:0]   low_len;
		logic [PERIOD_W-1:0] period_len;
		logic [DUTY_W-1:0]   duty;
		logic [FREQ_W-1:0]   freq;
	} period_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [RATE_WIDTH-1:0] tick_rate_hz = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  signal_level = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [HIGH_W-1:0]     high_ticks;
	logic [HIGH_W-1:0]     low_ticks;
	logic [PERIOD_W-1:0]   period_ticks;
	logic [DUTY_W-1:0]     duty_percent;
	logic [FREQ_W-1:0]     frequency_hz;

	// Model state of the meter.
	bit                    last_level;
	bit                    armed;
	bit                    timing_high;
	bit [HIGH_W-1:0]       phase_len;
	bit [HIGH_W-1:0]       held_high_len;
	bit [RATE_WIDTH-1:0]   rate_now = TICK_RATE_RESET;
	period_result_t        pending_periods[$];

	bit                    calm;
	bit                    took_result;
	int                    stall_left;
	int                    error_count;
	int                    levels_sent;
	int                    cycle_count;

	pwm_period_duty_meter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.tick_rate_hz(tick_rate_hz),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.signal_level(signal_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.high_ticks(high_ticks),
		.low_ticks(low_ticks),
		.period_ticks(period_ticks),
		.duty_percent(duty_percent),
		.frequency_hz(frequency_hz)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void track_level(input bit lvl);
		bit rise;
		bit fall;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned per;
		longint unsigned duty;
		longint unsigned freq;
		period_result_t r;
		rise = lvl && !last_level;
		fall = !lvl && last_level;
		last_level = lvl;
		if (!armed) begin
			if (rise) begin
				armed = 1'b1;
				timing_high = 1'b1;
				phase_len = 1;
			end
		end else if (timing_high && fall) begin
			held_high_len = phase_len;
			timing_high = 1'b0;
			phase_len = 1;
		end else if (!timing_high && rise) begin
			hi = held_high_len;
			lo = phase_len;
			per = hi + lo;
			duty = 0;
			freq = 0;
			if (per != 0) begin
				duty = (hi * DUTY_SCALE) / per;
				freq = rate_now / per;
			end
			if (freq > (64'd1 << FREQ_W) - 1)
				freq = (64'd1 << FREQ_W) - 1;
			r.high_len = hi[HIGH_W-1:0];
			r.low_len = lo[HIGH_W-1:0];
			r.period_len = per[PERIOD_W-1:0];
			r.duty = duty[DUTY_W-1:0];
			r.freq = freq[FREQ_W-1:0];
			pending_periods.push_back(r);
			timing_high = 1'b1;
			phase_len = 1;
		end else if (phase_len != '1) begin
			phase_len++;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_level(input bit lvl);
		int gap;
		gap = draw_wait();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		signal_level <= lvl;
		do @(posedge clk); while (in_stall);
		track_level(lvl);
		levels_sent++;
		@(negedge clk);
	endtask

	task automatic send_period(input int high_len, input int low_len);
		repeat (high_len) send_level(1'b1);
		repeat (low_len) send_level(1'b0);
	endtask

	// The register is only written once the meter has gone quiet.
	task automatic write_tick_rate(input logic [RATE_WIDTH-1:0] rate);
		in_valid <= 1'b0;
		while (pending_periods.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		tick_rate_hz <= rate;
		do @(posedge clk); while (!cfg_ready);
		rate_now = rate;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int draw_run();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(9, 100) : $urandom_range(1, 8);
	endfunction

	// A first sample of one arms the meter at once, then the shortest periods follow.
	task automatic test_first_edge_and_short_periods();
		send_period(1, 1);
		send_period(1, 1);
		send_period(3, 2);
		send_period(2, 5);
		send_period(4, 1);
		send_level(1'b1);
	endtask

	task automatic test_tick_rate_extremes();
		logic [RATE_WIDTH-1:0] rates[5];
		rates = '{27'd1, 27'd100000000, 27'd0, RATE_TOP, 27'd0};
		rates[4] = RATE_WIDTH'($urandom_range(1, 100000000));
		foreach (rates[i]) begin
			write_tick_rate(rates[i]);
			send_period(1, 1);
			send_period(2, 3);
			if (rates[i] == 27'd100000000) begin
				send_period(1, 130);
				send_period(130, 1);
			end
			send_level(1'b1);
		end
	endtask

	task automatic test_random_periods();
		int start;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0)
				write_tick_rate(TICK_RATE_RESET);
			else if (phase == 3)
				write_tick_rate(RATE_WIDTH'($urandom_range(0, RATE_TOP)));
			else
				write_tick_rate(RATE_WIDTH'($urandom_range(1, 100000000)));
			start = levels_sent;
			while (levels_sent - start < 175) begin
				calm = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 12)) send_level(1'($urandom_range(0, 1)));
				else
					send_period(draw_run(), draw_run());
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		period_result_t got;
		period_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			took_result = 1'b1;
			got.high_len = high_ticks;
			got.low_len = low_ticks;
			got.period_len = period_ticks;
			got.duty = duty_percent;
			got.freq = frequency_hz;
			if (pending_periods.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result: high %0d low %0d period %0d duty %0d freq %0d",
						got.high_len, got.low_len, got.period_len, got.duty, got.freq);
			end else begin
				want = pending_periods.pop_front();
				if (got.high_len !== want.high_len || got.low_len !== want.low_len ||
						got.period_len !== want.period_len || got.duty !== want.duty ||
						got.freq !== want.freq) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("result mismatch: expected high %0d low %0d period %0d duty %0d freq %0d",
							want.high_len, want.low_len, want.period_len, want.duty, want.freq);
						$display("                 got high %0d low %0d period %0d duty %0d freq %0d",
							got.high_len, got.low_len, got.period_len, got.duty, got.freq);
					end
				end
			end
		end
	end

	// A fresh stall length is drawn after every output transfer.
	always @(negedge clk) begin
		if (took_result) begin
			stall_left = draw_wait();
			took_result = 1'b0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_first_edge_and_short_periods();
		test_tick_rate_extremes();
		test_random_periods();
		in_valid <= 1'b0;
		while (pending_periods.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && pending_periods.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
